// ===== src/c8exu_pkg.sv =====
package c8exu_pkg;

   // Instruction groups, selected by the top nibble of the opcode
   localparam logic [3:0] GRP_JUMP        = 4'h1;
   localparam logic [3:0] GRP_SKIP_EQ_IMM = 4'h3;
   localparam logic [3:0] GRP_SKIP_NE_IMM = 4'h4;
   localparam logic [3:0] GRP_SKIP_EQ_REG = 4'h5;
   localparam logic [3:0] GRP_LOAD_IMM    = 4'h6;
   localparam logic [3:0] GRP_ADD_IMM     = 4'h7;
   localparam logic [3:0] GRP_ALU         = 4'h8;
   localparam logic [3:0] GRP_SKIP_NE_REG = 4'h9;
   localparam logic [3:0] GRP_LOAD_INDEX  = 4'hA;
   localparam logic [3:0] GRP_JUMP_V0     = 4'hB;
   localparam logic [3:0] GRP_RANDOM      = 4'hC;
   localparam logic [3:0] GRP_MISC        = 4'hF;

   // ALU operations, selected by the low nibble
   localparam logic [3:0] ALU_MOVE = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // Miscellaneous operations, selected by the low byte
   localparam logic [7:0] MISC_GET_DELAY  = 8'h07;
   localparam logic [7:0] MISC_SET_DELAY  = 8'h15;
   localparam logic [7:0] MISC_SET_SOUND  = 8'h18;
   localparam logic [7:0] MISC_ADD_INDEX  = 8'h1E;
   localparam logic [7:0] MISC_SPRITE_LOC = 8'h29;

   localparam logic [3:0] REG_NUM_NONE  = 4'h0;
   localparam logic [3:0] REG_NUM_FLAG  = 4'hF;
   localparam logic [3:0] SKIP_FORM_NUM = 4'h0;

   typedef struct packed {
      logic        skip_next;
      logic        jump_taken;
      logic [12:0] jump_target;
      logic        reg_write;
      logic [3:0]  reg_number;
      logic [7:0]  reg_value;
      logic        flag_value;
      logic [15:0] index_now;
      logic        delay_write;
      logic        sound_write;
      logic [7:0]  timer_value;
   } result_type;

endpackage

// ===== src/chip8_register_alu_execute_unit.sv =====
// Register and ALU execute unit: takes one 16-bit instruction per request and
// returns one result per request, holding sixteen 8-bit V registers and the 16-bit
// index register, all cleared by reset. A request is registered on entry,
// executed against the register file once the output register is empty or
// being drained, and its result lands in the output register at the same edge
// that updates the registers. One request per cycle is sustained while
// rsp_stall stays low. The next request always sees the registers as left by
// the one before it. ALU operands are the values before the instruction; a flag
// operation writes Vx first and VF last. Unsupported opcodes return all fields
// zero except index_now.
module chip8_register_alu_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_opcode,
   input  logic [7:0]  req_random_byte,
   input  logic [7:0]  req_delay_timer_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_skip_next,
   output logic        rsp_jump_taken,
   output logic [12:0] rsp_jump_target,
   output logic        rsp_reg_write,
   output logic [3:0]  rsp_reg_number,
   output logic [7:0]  rsp_reg_value,
   output logic        rsp_flag_value,
   output logic [15:0] rsp_index_now,
   output logic        rsp_delay_write,
   output logic        rsp_sound_write,
   output logic [7:0]  rsp_timer_value
);

   logic                     op_valid_ff;
   logic [15:0]              op_ff;
   logic [7:0]               rnd_ff;
   logic [7:0]               dtm_ff;
   logic                     rsp_valid_ff;
   c8exu_pkg::result_type    rsp_ff;
   c8exu_pkg::result_type    res_in;
   logic [7:0]               v_ff [16];
   logic [15:0]              index_ff;
   logic [15:0]              index_in;

   logic                     advance;
   logic [3:0]               grp;
   logic [3:0]               x_num;
   logic [3:0]               y_num;
   logic [3:0]               n_num;
   logic [7:0]               kk;
   logic [11:0]              nnn;
   logic [7:0]               vx;
   logic [7:0]               vy;
   logic [8:0]               sum_xy;
   logic                     vwr;
   logic [7:0]               vval;
   logic                     fwr;
   logic                     fval;

   // Execute when the output register is empty or being drained
   assign advance   = op_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = op_valid_ff && !advance;

   assign grp   = op_ff[15:12];
   assign x_num = op_ff[11:8];
   assign y_num = op_ff[7:4];
   assign n_num = op_ff[3:0];
   assign kk    = op_ff[7:0];
   assign nnn   = op_ff[11:0];
   assign vx    = v_ff[x_num];
   assign vy    = v_ff[y_num];
   assign sum_xy = {1'b0, vx} + {1'b0, vy};

   always_comb begin
      res_in   = '0;
      index_in = index_ff;
      vwr      = 1'b0;
      vval     = '0;
      fwr      = 1'b0;
      fval     = 1'b0;
      case (grp)
         c8exu_pkg::GRP_JUMP: begin
            res_in.jump_taken  = 1'b1;
            res_in.jump_target = {1'b0, nnn};
         end
         c8exu_pkg::GRP_SKIP_EQ_IMM: res_in.skip_next = (vx == kk);
         c8exu_pkg::GRP_SKIP_NE_IMM: res_in.skip_next = (vx != kk);
         c8exu_pkg::GRP_SKIP_EQ_REG:
            res_in.skip_next = (n_num == c8exu_pkg::SKIP_FORM_NUM) && (vx == vy);
         c8exu_pkg::GRP_SKIP_NE_REG:
            res_in.skip_next = (n_num == c8exu_pkg::SKIP_FORM_NUM) && (vx != vy);
         c8exu_pkg::GRP_LOAD_IMM: begin
            vwr  = 1'b1;
            vval = kk;
         end
         c8exu_pkg::GRP_ADD_IMM: begin
            vwr  = 1'b1;
            vval = vx + kk;
         end
         c8exu_pkg::GRP_ALU: begin
            case (n_num)
               c8exu_pkg::ALU_MOVE: begin
                  vwr  = 1'b1;
                  vval = vy;
               end
               c8exu_pkg::ALU_OR: begin
                  vwr  = 1'b1;
                  vval = vx | vy;
               end
               c8exu_pkg::ALU_AND: begin
                  vwr  = 1'b1;
                  vval = vx & vy;
               end
               c8exu_pkg::ALU_XOR: begin
                  vwr  = 1'b1;
                  vval = vx ^ vy;
               end
               c8exu_pkg::ALU_ADD: begin
                  vwr  = 1'b1;
                  vval = sum_xy[7:0];
                  fwr  = 1'b1;
                  fval = sum_xy[8];
               end
               c8exu_pkg::ALU_SUB: begin
                  vwr  = 1'b1;
                  vval = vx - vy;
                  fwr  = 1'b1;
                  fval = (vx >= vy);
               end
               c8exu_pkg::ALU_SHR: begin
                  vwr  = 1'b1;
                  vval = {1'b0, vx[7:1]};
                  fwr  = 1'b1;
                  fval = vx[0];
               end
               c8exu_pkg::ALU_SUBN: begin
                  vwr  = 1'b1;
                  vval = vy - vx;
                  fwr  = 1'b1;
                  fval = (vy >= vx);
               end
               c8exu_pkg::ALU_SHL: begin
                  vwr  = 1'b1;
                  vval = {vx[6:0], 1'b0};
                  fwr  = 1'b1;
                  fval = vx[7];
               end
               default: ;
            endcase
         end
         c8exu_pkg::GRP_LOAD_INDEX: index_in = {4'h0, nnn};
         c8exu_pkg::GRP_JUMP_V0: begin
            res_in.jump_taken  = 1'b1;
            res_in.jump_target = {1'b0, nnn} + {5'h00, v_ff[0]};
         end
         c8exu_pkg::GRP_RANDOM: begin
            vwr  = 1'b1;
            vval = rnd_ff & kk;
         end
         c8exu_pkg::GRP_MISC: begin
            case (kk)
               c8exu_pkg::MISC_GET_DELAY: begin
                  vwr  = 1'b1;
                  vval = dtm_ff;
               end
               c8exu_pkg::MISC_SET_DELAY: begin
                  res_in.delay_write = 1'b1;
                  res_in.timer_value = vx;
               end
               c8exu_pkg::MISC_SET_SOUND: begin
                  res_in.sound_write = 1'b1;
                  res_in.timer_value = vx;
               end
               c8exu_pkg::MISC_ADD_INDEX: index_in = index_ff + {8'h00, vx};
               // times five as shift plus add
               c8exu_pkg::MISC_SPRITE_LOC:
                  index_in = {6'h00, vx, 2'b00} + {8'h00, vx};
               default: ;
            endcase
         end
         default: ;
      endcase
      res_in.reg_write  = vwr;
      res_in.reg_number = vwr ? x_num : c8exu_pkg::REG_NUM_NONE;
      res_in.reg_value  = vval;
      res_in.flag_value = fval;
      res_in.index_now  = index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         index_ff     <= '0;
         for (int i = 0; i < 16; i++) begin
            v_ff[i] <= '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            op_valid_ff <= 1'b1;
         end else if (advance) begin
            op_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            index_ff <= index_in;
            // flag goes last, so drop the result write when x is VF
            if (vwr && !(fwr && x_num == c8exu_pkg::REG_NUM_FLAG)) begin
               v_ff[x_num] <= vval;
            end
            if (fwr) begin
               v_ff[c8exu_pkg::REG_NUM_FLAG] <= {7'h00, fval};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff  <= req_opcode;
         rnd_ff <= req_random_byte;
         dtm_ff <= req_delay_timer_now;
      end
      if (advance) begin
         rsp_ff <= res_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_skip_next   = rsp_ff.skip_next;
   assign rsp_jump_taken  = rsp_ff.jump_taken;
   assign rsp_jump_target = rsp_ff.jump_target;
   assign rsp_reg_write   = rsp_ff.reg_write;
   assign rsp_reg_number  = rsp_ff.reg_number;
   assign rsp_reg_value   = rsp_ff.reg_value;
   assign rsp_flag_value  = rsp_ff.flag_value;
   assign rsp_index_now   = rsp_ff.index_now;
   assign rsp_delay_write = rsp_ff.delay_write;
   assign rsp_sound_write = rsp_ff.sound_write;
   assign rsp_timer_value = rsp_ff.timer_value;

endmodule
